FILE: sv/audio_transport_loop_counter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the transport loop counter
// Each macro expands to one labeled concurrent assertion on a clock and an
// active-low reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_TRANSPORT_LOOP_COUNTER_TOP_ASSERT_SVH
`define AUDIO_TRANSPORT_LOOP_COUNTER_TOP_ASSERT_SVH

// same-cycle implication
`define ATLC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ATLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/atlc_pkg.sv
// ----------------------------------------------------------------------------
// atlc_pkg
// Types, codes and constants shared by the transport loop counter files.
// ----------------------------------------------------------------------------
`default_nettype none

package atlc_pkg;

    localparam int POSITION_BITS = 48;
    localparam int BLOCK_BITS    = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    // command codes
    localparam logic [1:0] OP_ADVANCE = 2'd0;
    localparam logic [1:0] OP_PLAY    = 2'd1;
    localparam logic [1:0] OP_STOP    = 2'd2;
    localparam logic [1:0] OP_PAUSE   = 2'd3;

    // transport states
    localparam logic [1:0] TS_STOPPED = 2'd0;
    localparam logic [1:0] TS_PLAYING = 2'd1;
    localparam logic [1:0] TS_PAUSED  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEMPO      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_EN    = 3'd4;

    // register reset values
    localparam logic [17:0] TEMPO_RESET = 18'd30720;
    localparam logic [17:0] RATE_RESET  = 18'd48000;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [BLOCK_BITS-1:0] block_samples;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  transport_state;
        logic [47:0] sample_position;
        logic [47:0] quarter_position_q16;
    } t_out_item;

endpackage

`default_nettype wire

FILE: sv/audio_transport_loop_counter_top.sv
// ----------------------------------------------------------------------------
// audio_transport_loop_counter_top
// Playhead with play/stop/pause, block advance, loop wrap and quarter-note
// position, computed by a shared multiplier and bit-serial divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  A command is taken in S_IDLE and runs through the quarter-note steps S_QLO,
//  S_QHI and S_QDIV to S_OUT; the next command is taken once that result is
//  taken. A looped advance while playing adds two loop point conversions
//  and, on a wrap, a modulo, all on the one-bit-per-cycle divider. One command
//  is in flight at a time; a result waits in the output
//  register until taken. Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_transport_loop_counter_top
    import atlc_pkg::*;
#(
    parameter int P_POSITION_BITS = POSITION_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW    = P_POSITION_BITS;
    localparam int DIV_W = PW + 26;
    localparam int EXT_W = (PW > 48) ? PW : 48;

    typedef enum logic [3:0] {
        S_IDLE, S_LS_MUL, S_LS_DIV, S_LE_MUL, S_LE_DIV, S_WRAP, S_MOD,
        S_QLO, S_QHI, S_QDIV, S_OUT
    } t_state;

    t_state            r_state;
    logic [17:0]       r_tempo;
    logic [17:0]       r_rate;
    logic [31:0]       r_loop_start;
    logic [31:0]       r_loop_end;
    logic              r_loop_en;
    logic [1:0]        r_play;
    logic [PW-1:0]     r_pos;
    logic [PW-1:0]     r_s;
    logic [PW-1:0]     r_e;
    logic [DIV_W-1:0]  r_prod;
    t_out_item         r_out;

    logic [17:0]       tempo_nz;
    logic [17:0]       rate_nz;
    logic [25:0]       k_val;
    logic [23:0]       d_val;
    logic [31:0]       mul_a;
    logic [25:0]       mul_b;
    logic [57:0]       mul_p;
    logic [63:0]       pos_ext;
    logic [PW:0]       add_sum;
    logic [PW-1:0]     pos_adv;
    logic              div_start;
    logic [DIV_W-1:0]  div_num;
    logic [PW-1:0]     div_den;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic [PW-1:0]     div_rem;
    logic [PW-1:0]     quo_sat;
    logic [47:0]       quarter;
    logic [EXT_W-1:0]  pos_wide;
    logic [47:0]       pos_out;

    // scale factors: k = 256 * tempo, d = 60 * rate
    assign tempo_nz = (r_tempo == '0) ? 18'd1 : r_tempo;
    assign rate_nz  = (r_rate == '0) ? 18'd1 : r_rate;
    assign k_val    = {tempo_nz, 8'd0};
    assign d_val    = {rate_nz, 6'd0} - {4'd0, rate_nz, 2'd0};

    // shared multiplier operand select
    assign pos_ext = 64'(r_pos);
    always_comb begin
        case (r_state)
            S_LS_MUL: begin mul_a = r_loop_start;   mul_b = 26'(d_val); end
            S_LE_MUL: begin mul_a = r_loop_end;     mul_b = 26'(d_val); end
            S_QLO:    begin mul_a = pos_ext[31:0];  mul_b = k_val;      end
            S_QHI:    begin mul_a = pos_ext[63:32]; mul_b = k_val;      end
            default:  begin mul_a = '0;             mul_b = '0;         end
        endcase
    end
    assign mul_p = 58'(mul_a) * 58'(mul_b);

    // divider launch and operand select
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            S_LS_MUL, S_LE_MUL: begin
                div_start = 1'b1;
                div_num   = DIV_W'(mul_p);
                div_den   = PW'(k_val);
            end
            S_WRAP: begin
                div_start = (r_pos >= r_e) && (r_e > r_s);
                div_num   = DIV_W'(r_pos - r_s);
                div_den   = r_e - r_s;
            end
            S_QHI: begin
                div_start = 1'b1;
                div_num   = r_prod + (DIV_W'(mul_p) << 32);
                div_den   = PW'(d_val);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    atlc_div #(
        .N_W (DIV_W),
        .D_W (PW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_num),
        .i_divisor   (div_den),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // saturate quotients and the advanced position
    assign quo_sat = (|div_quo[DIV_W-1:PW]) ? '1 : div_quo[PW-1:0];
    assign quarter = (|div_quo[DIV_W-1:48]) ? '1 : div_quo[47:0];
    assign add_sum = {1'b0, r_pos} + (PW+1)'(i_in_item.block_samples);
    assign pos_adv = add_sum[PW] ? '1 : add_sum[PW-1:0];
    assign pos_wide = EXT_W'(r_pos);
    assign pos_out  = (pos_wide > EXT_W'(48'hFFFF_FFFF_FFFF)) ? '1 : pos_wide[47:0];

    // sequencer, registers and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tempo      <= TEMPO_RESET;
            r_rate       <= RATE_RESET;
            r_loop_start <= '0;
            r_loop_end   <= '0;
            r_loop_en    <= 1'b0;
            r_play       <= TS_STOPPED;
            r_pos        <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TEMPO:      r_tempo      <= i_cfg_data[17:0];
                    REG_RATE:       r_rate       <= i_cfg_data[17:0];
                    REG_LOOP_START: r_loop_start <= i_cfg_data;
                    REG_LOOP_END:   r_loop_end   <= i_cfg_data;
                    REG_LOOP_EN:    r_loop_en    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_QLO;
                        case (i_in_item.opcode)
                            OP_ADVANCE: begin
                                if (r_play == TS_PLAYING) begin
                                    r_pos <= pos_adv;
                                    if (r_loop_en) begin
                                        r_state <= S_LS_MUL;
                                    end
                                end
                            end
                            OP_PLAY:  r_play <= TS_PLAYING;
                            OP_STOP: begin
                                r_play <= TS_STOPPED;
                                r_pos  <= '0;
                            end
                            default:  r_play <= TS_PAUSED;
                        endcase
                    end
                end
                S_LS_MUL: r_state <= S_LS_DIV;
                S_LS_DIV: begin
                    if (div_done) begin
                        r_s     <= quo_sat;
                        r_state <= S_LE_MUL;
                    end
                end
                S_LE_MUL: r_state <= S_LE_DIV;
                S_LE_DIV: begin
                    if (div_done) begin
                        r_e     <= quo_sat;
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    // wrap into the loop, or snap to start on an empty loop
                    if (r_pos >= r_e) begin
                        if (r_e > r_s) begin
                            r_state <= S_MOD;
                        end else begin
                            r_pos   <= r_s;
                            r_state <= S_QLO;
                        end
                    end else begin
                        r_state <= S_QLO;
                    end
                end
                S_MOD: begin
                    if (div_done) begin
                        r_pos   <= r_s + div_rem;
                        r_state <= S_QLO;
                    end
                end
                S_QLO: begin
                    r_prod  <= DIV_W'(mul_p);
                    r_state <= S_QHI;
                end
                S_QHI: r_state <= S_QDIV;
                S_QDIV: begin
                    if (div_done) begin
                        r_out.transport_state      <= r_play;
                        r_out.sample_position      <= pos_out;
                        r_out.quarter_position_q16 <= quarter;
                        r_state                    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: sv/atlc_div.sv
// ----------------------------------------------------------------------------
// atlc_div
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module atlc_div #(
    parameter int N_W = 74,
    parameter int D_W = 48
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_dividend,
    input  wire logic [D_W-1:0] i_divisor,
    output logic                o_done,
    output logic [N_W-1:0]      o_quotient,
    output logic [D_W-1:0]      o_remainder
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_quo;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [D_W:0]     trial;
    logic             ge;

    // trial subtract of the next partial remainder
    assign trial = {r_rem, r_quo[N_W-1]};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: load operands, then shift one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[N_W-2:0], ge};
            r_rem <= ge ? D_W'(trial - {1'b0, r_den}) : trial[D_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

FILE: sv/atlc_checker.sv
// ----------------------------------------------------------------------------
// atlc_checker
// Port-level checks of the transport loop counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "audio_transport_loop_counter_top_assert.svh"

module atlc_checker
    import atlc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    // an accepted item keeps the block busy on the next cycle
    `ATLC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // no new item while a result waits
    `ATLC_ASSERT_NOW(a_hold_while_out, i_clk, i_rst_n, o_out_valid, o_in_stall)

    // a stopped transport sits at zero
    `ATLC_ASSERT_NOW(a_stop_at_zero, i_clk, i_rst_n, o_out_valid && (o_out_item.transport_state == TS_STOPPED), o_out_item.sample_position == 48'd0 && o_out_item.quarter_position_q16 == 48'd0)

    // a stalled result holds
    `ATLC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

endmodule

bind audio_transport_loop_counter_top atlc_checker u_atlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
